// File: design/htrf_pkg.sv
// Shared types, codes and the sequencer program for the three-rectangle Haar feature block.
package htrf_pkg;

    // Default sizes of the integral image store
    localparam int MAX_ROWS_DEF    = 128;
    localparam int MAX_COLS_DEF    = 128;
    localparam int ENTRY_WIDTH_DEF = 32;

    // Field widths fixed by the item layout
    localparam int POS_W   = 7;
    localparam int WVAL_W  = 32;
    localparam int SIZE_W  = 8;
    localparam int CFG_W   = 8;
    localparam int FEAT_W  = 34;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 40;
    // Window coordinate sums and effective image size
    localparam int COORD_W = 9;
    localparam int DIM_W   = 11;

    localparam longint FEAT_MAX = 64'sd8589934591;
    localparam longint FEAT_MIN = -64'sd8589934592;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_WIDTH   = 2'd1,
        ST_SMALL   = 2'd2,
        ST_OUTSIDE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_READ   = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    // Column points of the window: left quarter, centre half, right quarter
    typedef enum logic [2:0] {
        COL_X       = 3'd0,
        COL_L_END   = 3'd1,
        COL_C_BEGIN = 3'd2,
        COL_C_END   = 3'd3,
        COL_R_BEGIN = 3'd4,
        COL_R_END   = 3'd5
    } col_sel_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_START  = 4'd0;
    localparam step_t STEP_FINISH = 4'd14;

    typedef struct packed {
        op_t      op;
        logic     row_bot;  // 1: bottom row, 0: top row
        col_sel_t col;
        logic     neg;      // subtract the corner instead of adding it
        step_t    next;
        step_t    jump;     // taken by the check step when the window is rejected
    } ctrl_word_t;

    function automatic ctrl_word_t cw(input op_t op, input logic row_bot,
                                      input col_sel_t col, input logic neg,
                                      input step_t next, input step_t jump);
        ctrl_word_t w;
        w.op      = op;
        w.row_bot = row_bot;
        w.col     = col;
        w.neg     = neg;
        w.next    = next;
        w.jump    = jump;
        return w;
    endfunction

    // Program: check, twelve corner reads, drain the read pipe, deliver.
    // Left and right sums add, the centre sum is taken with flipped signs.
    function automatic ctrl_word_t prog_rom(input step_t s);
        ctrl_word_t w;
        case (s)
            4'd0:    w = cw(OP_CHECK,  1'b0, COL_X,       1'b0, 4'd1,  STEP_FINISH);
            4'd1:    w = cw(OP_READ,   1'b1, COL_L_END,   1'b0, 4'd2,  4'd2);
            4'd2:    w = cw(OP_READ,   1'b0, COL_X,       1'b0, 4'd3,  4'd3);
            4'd3:    w = cw(OP_READ,   1'b0, COL_L_END,   1'b1, 4'd4,  4'd4);
            4'd4:    w = cw(OP_READ,   1'b1, COL_X,       1'b1, 4'd5,  4'd5);
            4'd5:    w = cw(OP_READ,   1'b1, COL_R_END,   1'b0, 4'd6,  4'd6);
            4'd6:    w = cw(OP_READ,   1'b0, COL_R_BEGIN, 1'b0, 4'd7,  4'd7);
            4'd7:    w = cw(OP_READ,   1'b0, COL_R_END,   1'b1, 4'd8,  4'd8);
            4'd8:    w = cw(OP_READ,   1'b1, COL_R_BEGIN, 1'b1, 4'd9,  4'd9);
            4'd9:    w = cw(OP_READ,   1'b1, COL_C_END,   1'b1, 4'd10, 4'd10);
            4'd10:   w = cw(OP_READ,   1'b0, COL_C_BEGIN, 1'b1, 4'd11, 4'd11);
            4'd11:   w = cw(OP_READ,   1'b0, COL_C_END,   1'b0, 4'd12, 4'd12);
            4'd12:   w = cw(OP_READ,   1'b1, COL_C_BEGIN, 1'b0, 4'd13, 4'd13);
            4'd13:   w = cw(OP_DRAIN,  1'b0, COL_X,       1'b0, 4'd14, 4'd14);
            default: w = cw(OP_FINISH, 1'b0, COL_X,       1'b0, STEP_START, STEP_START);
        endcase
        return w;
    endfunction

endpackage

// File: design/htrf_ram.sv
// Generic single-port RAM with registered read.
module htrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/haar_three_rect_feature.sv
// Three-rectangle Haar feature over an integral image held in a column-major RAM.
//
// Input channel s_axis_*: tuser selects the action (0 write, 1 query). A write
// transfer stores one integral entry at (row, col) in a single cycle and gives
// no result. A query transfer names a window (x, y, w, h) and gives one result
// on m_axis_*: the saturated left + right - centre sum in tdata and a status
// code in tuser (0 ok, 1 width not a multiple of 4, 2 window too small,
// 3 window outside the image); the sum is zero when status is not ok.
// A query runs a 15-step microprogram: one check step, twelve corner reads
// through the single RAM port (one per cycle), one step to drain the read
// pipe, one step to deliver. The result is registered at the same edge that
// raises tready; a rejected window goes from the check step straight to the
// deliver step. No new query or write is taken until the last query is
// delivered. Writes sustain one per cycle while no query runs.
// The result sits in an output register: while the receiver stalls, writes
// and the next query are still taken; a query that finishes while the
// previous result waits holds in its deliver step. Configuration (cfg_we,
// cfg_addr, cfg_wdata) sets the image height and width used for bounds tests.
// Reset clears the sequencer and output valid and sets both sizes to 128; the RAM
// is not cleared and entries read by a query must be written first.
module haar_three_rect_feature #(
    parameter int MAX_ROWS    = htrf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = htrf_pkg::MAX_COLS_DEF,
    parameter int ENTRY_WIDTH = htrf_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // write_row[6:0], write_col[13:7], write_value[45:14], win_x[52:46],
    // win_y[59:53], win_w[67:60], win_h[75:68], zero fill [79:76]
    input  logic [htrf_pkg::IN_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                       s_axis_tuser,
    // result channel
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // feature_value[33:0] (signed), zero fill [39:34]
    output logic [htrf_pkg::OUT_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [htrf_pkg::STAT_W-1:0] m_axis_tuser,
    // configuration
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [htrf_pkg::CFG_W-1:0] cfg_wdata
);

    import htrf_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int ACC_W  = (ENTRY_WIDTH + 4 > FEAT_W + 1) ? ENTRY_WIDTH + 4 : FEAT_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(FEAT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(FEAT_MIN);

    // ---------------------------------------------------------------- fields
    logic [POS_W-1:0]  in_wr_row, in_wr_col, in_x, in_y;
    logic [WVAL_W-1:0] in_wr_val;
    logic [SIZE_W-1:0] in_w, in_h;

    assign in_wr_row = s_axis_tdata[6:0];
    assign in_wr_col = s_axis_tdata[13:7];
    assign in_wr_val = s_axis_tdata[45:14];
    assign in_x      = s_axis_tdata[52:46];
    assign in_y      = s_axis_tdata[59:53];
    assign in_w      = s_axis_tdata[67:60];
    assign in_h      = s_axis_tdata[75:68];

    function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col);
        logic [31:0] a;
        a = 32'(col) * 32'(MAX_ROWS) + 32'(row);
        return a[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] rows_reg, cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_W'(128);
            cols_reg <= CFG_W'(128);
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ROWS: rows_reg <= cfg_wdata;
                REG_COLS: cols_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    logic busy_reg;
    logic in_fire, wr_fire, q_fire;

    assign s_axis_tready = !busy_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign wr_fire = in_fire && (action_t'(s_axis_tuser) == ACT_WRITE);
    assign q_fire  = in_fire && (action_t'(s_axis_tuser) == ACT_QUERY);

    // ---------------------------------------------------------------- window check
    logic [DIM_W-1:0] rows_eff, cols_eff;
    logic [DIM_W-1:0] x_end, y_end;
    status_t          status_in;

    always_comb begin
        rows_eff = (int'(rows_reg) < MAX_ROWS) ? DIM_W'(rows_reg) : DIM_W'(MAX_ROWS);
        cols_eff = (int'(cols_reg) < MAX_COLS) ? DIM_W'(cols_reg) : DIM_W'(MAX_COLS);
        x_end    = DIM_W'(in_x) + DIM_W'(in_w);
        y_end    = DIM_W'(in_y) + DIM_W'(in_h);
        if (in_w[1:0] != 2'b00) begin
            status_in = ST_WIDTH;
        end else if (in_w <= SIZE_W'(8) || in_h <= SIZE_W'(1)) begin
            status_in = ST_SMALL;
        end else if (x_end > cols_eff || y_end > rows_eff) begin
            status_in = ST_OUTSIDE;
        end else begin
            status_in = ST_OK;
        end
    end

    // ---------------------------------------------------------------- sequencer
    logic [POS_W-1:0]  x_reg, y_reg;
    logic [SIZE_W-1:0] w_reg, h_reg;
    status_t           status_reg;
    step_t             step_reg, step_next;
    ctrl_word_t        word;
    logic              out_free;
    logic              finish;

    assign word     = prog_rom(step_reg);
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign finish   = busy_reg && (word.op == OP_FINISH) && out_free;

    always_comb begin
        step_next = step_reg;
        if (busy_reg) begin
            case (word.op)
                OP_CHECK:  step_next = (status_reg != ST_OK) ? word.jump : word.next;
                OP_READ:   step_next = word.next;
                OP_DRAIN:  step_next = word.next;
                OP_FINISH: step_next = out_free ? word.next : step_reg;
                default:   step_next = word.next;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_START;
        end else begin
            if (q_fire) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_START;
            end else begin
                step_reg <= step_next;
                if (finish) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_fire) begin
            x_reg      <= in_x;
            y_reg      <= in_y;
            w_reg      <= in_w;
            h_reg      <= in_h;
            status_reg <= status_in;
        end
    end

    // ---------------------------------------------------------------- corner address
    logic [COORD_W-1:0] m1, m2, col_off, rd_col, rd_row;
    logic               rd_en;

    always_comb begin
        m1 = COORD_W'(w_reg[SIZE_W-1:2]);
        m2 = m1 + (m1 << 1);
        case (word.col)
            COL_X:       col_off = '0;
            COL_L_END:   col_off = m1 - COORD_W'(1);
            COL_C_BEGIN: col_off = m1;
            COL_C_END:   col_off = m2 - COORD_W'(1);
            COL_R_BEGIN: col_off = m2;
            COL_R_END:   col_off = COORD_W'(w_reg) - COORD_W'(1);
            default:     col_off = '0;
        endcase
        rd_col = COORD_W'(x_reg) + col_off;
        rd_row = word.row_bot ? (COORD_W'(y_reg) + COORD_W'(h_reg) - COORD_W'(1))
                              : COORD_W'(y_reg);
        rd_en  = busy_reg && (word.op == OP_READ);
    end

    // ---------------------------------------------------------------- store
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    // Drop writes outside the store
    assign ram_we   = wr_fire && (int'(in_wr_row) < MAX_ROWS) && (int'(in_wr_col) < MAX_COLS);
    assign ram_addr = busy_reg ? addr_of(rd_row, rd_col)
                               : addr_of(COORD_W'(in_wr_row), COORD_W'(in_wr_col));

    htrf_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ENTRY_WIDTH'(in_wr_val)),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- accumulate
    logic                    pend_reg, pend_neg_reg;
    logic signed [ACC_W-1:0] acc_reg, corner;

    assign corner = signed'({(ACC_W - ENTRY_WIDTH)'(0), ram_rdata});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        pend_neg_reg <= word.neg;
        if (q_fire) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            acc_reg <= pend_neg_reg ? acc_reg - corner : acc_reg + corner;
        end
    end

    // ---------------------------------------------------------------- output
    logic [FEAT_W-1:0] feat_sat;
    logic              m_valid_reg;
    logic [FEAT_W-1:0] feat_reg;
    status_t           m_status_reg;

    always_comb begin
        if (acc_reg > SAT_HI) begin
            feat_sat = FEAT_W'(SAT_HI);
        end else if (acc_reg < SAT_LO) begin
            feat_sat = FEAT_W'(SAT_LO);
        end else begin
            feat_sat = acc_reg[FEAT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            feat_reg     <= (status_reg == ST_OK) ? feat_sat : '0;
            m_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OUT_W - FEAT_W)'(0), feat_reg};
    assign m_axis_tuser  = m_status_reg;

    // ---------------------------------------------------------------- checks
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("rejected window delivered a nonzero feature");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fire |=> busy_reg && (step_reg == STEP_START))
        else $error("query transfer did not start the program");

    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> busy_reg && $past(rd_en))
        else $error("corner accumulated outside a query");

    a_err_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (status_reg != ST_OK) |-> !rd_en && (acc_reg == '0))
        else $error("rejected window read the store");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !busy_reg)
        else $error("store written during a query");

endmodule
